// File: sv/bhist_pkg.sv
// ============================================================================
// bhist_pkg: shared types, constants and microcode for the bin histogram
// Holds the field widths, request codes, the control word layout and the
// read-only program that the sequencer steps through.
// ============================================================================
`default_nettype none

package bhist_pkg;

  // Field widths.
  localparam int REQ_W   = 2;
  localparam int INDEX_W = 32;
  localparam int SCALE_W = 16;
  localparam int CNT_W   = 64;
  localparam int BINS_W  = 13;
  localparam int WIDTH_W = 32;
  localparam int PROD_W  = INDEX_W + SCALE_W;
  localparam int LIMIT_W = BINS_W + WIDTH_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_FINITE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INFINITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ     = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH   = 1'd1;

  // Register reset values.
  localparam logic [BINS_W-1:0]  BINS_RESET  = 13'd4096;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 32'd1;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LATCH,
    OP_MUL_PROD,
    OP_MUL_LIMIT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_RD_BIN,
    OP_ADD_BIN,
    OP_ADD_BEYOND,
    OP_ADD_INF,
    OP_RD_IDX,
    OP_TAKE_READ,
    OP_REJECT,
    OP_EMIT
  } op_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_INPUT,
    C_NOT_FINITE,
    C_NOT_INFINITE,
    C_NOT_READ,
    C_WIDTH_ZERO,
    C_NOT_BELOW,
    C_DIV_BUSY,
    C_IDX_OUT,
    C_OUT_FREE,
    C_CLR_BUSY
  } cond_t;

  // Status flags that the datapath hands to the sequencer.
  typedef struct packed {
    logic no_input;
    logic not_finite;
    logic not_infinite;
    logic not_read;
    logic width_zero;
    logic not_below;
    logic div_busy;
    logic idx_out;
    logic out_free;
    logic clr_busy;
  } status_t;

  localparam int PC_W = 5;

  // One control word: operation, jump condition and jump target.
  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // Program addresses.
  localparam logic [PC_W-1:0] PC_CLEAR     = 5'd0;
  localparam logic [PC_W-1:0] PC_WAIT      = 5'd1;
  localparam logic [PC_W-1:0] PC_DISPATCH  = 5'd2;
  localparam logic [PC_W-1:0] PC_MUL_PROD  = 5'd3;
  localparam logic [PC_W-1:0] PC_MUL_LIMIT = 5'd4;
  localparam logic [PC_W-1:0] PC_DIV_INIT  = 5'd5;
  localparam logic [PC_W-1:0] PC_DIV_STEP  = 5'd6;
  localparam logic [PC_W-1:0] PC_RD_BIN    = 5'd7;
  localparam logic [PC_W-1:0] PC_ADD_BIN   = 5'd8;
  localparam logic [PC_W-1:0] PC_BEYOND    = 5'd9;
  localparam logic [PC_W-1:0] PC_INF_TEST  = 5'd10;
  localparam logic [PC_W-1:0] PC_INF       = 5'd11;
  localparam logic [PC_W-1:0] PC_RD_TEST   = 5'd12;
  localparam logic [PC_W-1:0] PC_RD_IDX    = 5'd13;
  localparam logic [PC_W-1:0] PC_TAKE      = 5'd14;
  localparam logic [PC_W-1:0] PC_REJECT    = 5'd15;
  localparam logic [PC_W-1:0] PC_EMIT      = 5'd16;
  localparam logic [PC_W-1:0] PC_EMIT_WAIT = 5'd17;

  // The program. A taken condition jumps to the target, otherwise the
  // sequencer moves to the next address.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      PC_CLEAR:     w = '{OP_CLEAR,      C_CLR_BUSY,     PC_CLEAR};
      PC_WAIT:      w = '{OP_LATCH,      C_NO_INPUT,     PC_WAIT};
      PC_DISPATCH:  w = '{OP_NOP,        C_NOT_FINITE,   PC_INF_TEST};
      PC_MUL_PROD:  w = '{OP_MUL_PROD,   C_WIDTH_ZERO,   PC_REJECT};
      PC_MUL_LIMIT: w = '{OP_MUL_LIMIT,  C_NONE,         PC_WAIT};
      PC_DIV_INIT:  w = '{OP_DIV_INIT,   C_NOT_BELOW,    PC_BEYOND};
      PC_DIV_STEP:  w = '{OP_DIV_STEP,   C_DIV_BUSY,     PC_DIV_STEP};
      PC_RD_BIN:    w = '{OP_RD_BIN,     C_NONE,         PC_WAIT};
      PC_ADD_BIN:   w = '{OP_ADD_BIN,    C_ALWAYS,       PC_EMIT};
      PC_BEYOND:    w = '{OP_ADD_BEYOND, C_ALWAYS,       PC_EMIT};
      PC_INF_TEST:  w = '{OP_NOP,        C_NOT_INFINITE, PC_RD_TEST};
      PC_INF:       w = '{OP_ADD_INF,    C_ALWAYS,       PC_EMIT};
      PC_RD_TEST:   w = '{OP_NOP,        C_NOT_READ,     PC_REJECT};
      PC_RD_IDX:    w = '{OP_RD_IDX,     C_IDX_OUT,      PC_REJECT};
      PC_TAKE:      w = '{OP_TAKE_READ,  C_ALWAYS,       PC_EMIT};
      PC_REJECT:    w = '{OP_REJECT,     C_NONE,         PC_WAIT};
      PC_EMIT:      w = '{OP_EMIT,       C_OUT_FREE,     PC_WAIT};
      PC_EMIT_WAIT: w = '{OP_NOP,        C_ALWAYS,       PC_EMIT};
      default:      w = '{OP_NOP,        C_ALWAYS,       PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: sv/bhist_sequencer.sv
// ============================================================================
// bhist_sequencer: microcode step counter
// Fetches one control word per cycle from the program table, tests its jump
// condition against the datapath status and picks the next address.
// ============================================================================
`default_nettype none

module bhist_sequencer
  import bhist_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire status_t status,
  output op_t          op
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t          word;
  logic            hit;

  // Control word fetch.
  assign word = ucode_rom(pc);
  assign op   = word.op;

  // Jump condition select.
  always_comb begin
    unique case (word.cond)
      C_NONE:         hit = 1'b0;
      C_ALWAYS:       hit = 1'b1;
      C_NO_INPUT:     hit = status.no_input;
      C_NOT_FINITE:   hit = status.not_finite;
      C_NOT_INFINITE: hit = status.not_infinite;
      C_NOT_READ:     hit = status.not_read;
      C_WIDTH_ZERO:   hit = status.width_zero;
      C_NOT_BELOW:    hit = status.not_below;
      C_DIV_BUSY:     hit = status.div_busy;
      C_IDX_OUT:      hit = status.idx_out;
      C_OUT_FREE:     hit = status.out_free;
      C_CLR_BUSY:     hit = status.clr_busy;
      default:        hit = 1'b0;
    endcase
  end

  // Next address.
  always_comb begin
    if (hit) begin
      pc_next = word.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  // Step counter; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_CLEAR;
    end else begin
      pc <= pc_next;
    end
  end

`ifndef SYNTHESIS
  // An accepted word always moves on to the dispatch step.
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (pc == PC_WAIT && !status.no_input) |=> (pc == PC_DISPATCH))
    else $error("accepted word did not reach dispatch");

  // The clearing pass is not left before the last entry.
  a_clear_holds: assert property (@(posedge clk) disable iff (rst)
    (pc == PC_CLEAR && status.clr_busy) |=> (pc == PC_CLEAR))
    else $error("clearing pass left early");
`endif

endmodule

`default_nettype wire

// File: sv/bhist_datapath.sv
// ============================================================================
// bhist_datapath: registers, multiplier, divider and bin memory
// Carries out one microcode operation per cycle: latches a request, forms
// the range products, divides one quotient bit a cycle, updates the bin
// memory and the running totals, and holds the result word for the output.
// ============================================================================
`default_nettype none

module bhist_datapath
  import bhist_pkg::*;
#(
  parameter int MAX_BINS = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire op_t                  op,
  output status_t                   status,
  input  wire logic [BINS_W-1:0]    nb,
  input  wire logic [WIDTH_W-1:0]   bin_width,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [47:0]          s_tdata,   // index[31:0], scale[47:32]
  input  wire logic [REQ_W-1:0]     s_tuser,   // req_type[1:0]
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [4*CNT_W-1:0]        m_tdata,   // bin_value, total_sum,
                                               // beyond_range_total,
                                               // infinite_total
  output logic [0:0]                m_tuser    // ok[0]
);

  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CW = (AW > 1) ? $clog2(AW) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BINS - 1);
  localparam logic [CW-1:0] DIV_LAST  = CW'(AW - 1);

  // Latched request.
  logic [REQ_W-1:0]   req;
  logic [INDEX_W-1:0] idx;
  logic [SCALE_W-1:0] wt;

  // Range products and divider.
  logic [PROD_W-1:0]  prod;
  logic [LIMIT_W-1:0] limit;
  logic [PROD_W-1:0]  prod_mul;
  logic [LIMIT_W-1:0] limit_mul;
  logic [PROD_W-1:0]  rem;
  logic [PROD_W-1:0]  dvs;
  logic [AW-1:0]      quo;
  logic [CW-1:0]      dcnt;
  logic               ge;

  // Bin memory.
  logic [CNT_W-1:0]   mem [MAX_BINS];
  logic [CNT_W-1:0]   mem_rd;
  logic [CNT_W-1:0]   mem_wdata;
  logic [AW-1:0]      mem_addr;
  logic               mem_we;
  logic [AW-1:0]      clr_addr;

  // Result and totals.
  logic               ok;
  logic [CNT_W-1:0]   val;
  logic [CNT_W-1:0]   sum_cnt;
  logic [CNT_W-1:0]   beyond_cnt;
  logic [CNT_W-1:0]   inf_cnt;
  logic               out_free;

  assign s_tready  = (op == OP_LATCH);
  assign out_free  = !m_tvalid || m_tready;
  assign prod_mul  = wt * idx;
  assign limit_mul = nb * bin_width;
  assign ge        = (rem >= dvs);

  // Status flags for the sequencer.
  always_comb begin
    status.no_input     = !s_tvalid;
    status.not_finite   = (req != REQ_FINITE);
    status.not_infinite = (req != REQ_INFINITE);
    status.not_read     = (req != REQ_READ);
    status.width_zero   = (bin_width == '0);
    status.not_below    = (prod >= PROD_W'(limit));
    status.div_busy     = (dcnt != '0);
    status.idx_out      = (idx >= INDEX_W'(nb));
    status.out_free     = out_free;
    status.clr_busy     = (clr_addr != LAST_ADDR);
  end

  // Memory address and write data.
  always_comb begin
    unique case (op)
      OP_CLEAR:  mem_addr = clr_addr;
      OP_RD_IDX: mem_addr = idx[AW-1:0];
      default:   mem_addr = quo;
    endcase
  end

  assign mem_we    = (op == OP_CLEAR) || (op == OP_ADD_BIN);
  assign mem_wdata = (op == OP_CLEAR) ? '0 : mem_rd + CNT_W'(wt);

  // Bin memory: one port, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rd <= mem[mem_addr];
  end

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (op == OP_CLEAR && clr_addr != LAST_ADDR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Request latch, multiplier and restoring divider.
  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        req <= s_tuser;
        idx <= s_tdata[31:0];
        wt  <= s_tdata[47:32];
      end
      OP_MUL_PROD: begin
        prod <= prod_mul;
      end
      OP_MUL_LIMIT: begin
        limit <= limit_mul;
      end
      OP_DIV_INIT: begin
        rem  <= prod;
        dvs  <= PROD_W'(bin_width) << (AW - 1);
        quo  <= '0;
        dcnt <= DIV_LAST;
      end
      OP_DIV_STEP: begin
        if (ge) begin
          rem <= rem - dvs;
        end
        quo  <= (quo << 1) | AW'(ge);
        dvs  <= dvs >> 1;
        dcnt <= dcnt - CW'(1);
      end
      default: begin
      end
    endcase
  end

  // Result of the current request.
  always_ff @(posedge clk) begin
    case (op)
      OP_ADD_BIN: begin
        ok  <= 1'b1;
        val <= mem_wdata;
      end
      OP_ADD_BEYOND, OP_ADD_INF: begin
        ok  <= 1'b1;
        val <= '0;
      end
      OP_TAKE_READ: begin
        ok  <= 1'b1;
        val <= mem_rd;
      end
      OP_REJECT: begin
        ok  <= 1'b0;
        val <= '0;
      end
      default: begin
      end
    endcase
  end

  // Running totals, cleared at reset and wrapping at 64 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_cnt    <= '0;
      beyond_cnt <= '0;
      inf_cnt    <= '0;
    end else begin
      case (op)
        OP_ADD_BIN: begin
          sum_cnt <= sum_cnt + CNT_W'(wt);
        end
        OP_ADD_BEYOND: begin
          sum_cnt    <= sum_cnt + CNT_W'(wt);
          beyond_cnt <= beyond_cnt + CNT_W'(wt);
        end
        OP_ADD_INF: begin
          sum_cnt <= sum_cnt + CNT_W'(wt);
          inf_cnt <= inf_cnt + CNT_W'(wt);
        end
        default: begin
        end
      endcase
    end
  end

  // Output register; it holds its word while the next request is worked on.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (op == OP_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT && out_free) begin
      m_tdata <= {inf_cnt, beyond_cnt, sum_cnt, val};
      m_tuser <= ok;
    end
  end

`ifndef SYNTHESIS
  // The divided bin number always lies below the bins in use.
  a_bin_in_range: assert property (@(posedge clk) disable iff (rst)
    (op == OP_RD_BIN) |-> (32'(quo) < 32'(nb)))
    else $error("bin number beyond bins in use");

  // The running sum moves only on an insert.
  a_sum_on_insert: assert property (@(posedge clk) disable iff (rst)
    (op != OP_ADD_BIN && op != OP_ADD_BEYOND && op != OP_ADD_INF)
      |=> $stable(sum_cnt))
    else $error("running sum changed outside an insert");
`endif

endmodule

`default_nettype wire

// File: sv/binned_histogram_with_overflow.sv
// ============================================================================
// binned_histogram_with_overflow: fixed-width bin histogram with totals
// Top level: configuration registers, the microcode sequencer and the
// datapath with its bin memory.
// ============================================================================
// After reset the block first clears its bin memory, one entry a cycle, and
// takes no request in that time. Afterwards it works on one request at a
// time. A finite insert that lands in a bin runs the divider, which yields
// one quotient bit per cycle, and a read-modify-write on the single memory
// port. A finite insert past the last bin, a bin read, an infinite insert
// and a refused finite insert run no divider step. The output register
// holds one result word while the next request is worked on. Configuration
// writes are taken at any time and must only be made while the block is
// idle.
`default_nettype none

module binned_histogram_with_overflow
  import bhist_pkg::*;
#(
  parameter int MAX_BINS = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Request stream.
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [47:0]            s_tdata,   // index[31:0], scale[47:32]
  input  wire logic [REQ_W-1:0]       s_tuser,   // req_type[1:0]
  // Result stream.
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [4*CNT_W-1:0]          m_tdata,   // bin_value[63:0],
                                                 // total_sum[127:64],
                                                 // beyond_range_total[191:128],
                                                 // infinite_total[255:192]
  output logic [0:0]                  m_tuser,   // ok[0]
  // Configuration writes.
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [BINS_W-1:0]  bins_in_use;
  logic [WIDTH_W-1:0] bin_width;
  logic [BINS_W-1:0]  nb;
  status_t            status;
  op_t                op;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bins_in_use <= BINS_RESET;
      bin_width   <= WIDTH_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_BINS_IN_USE) begin
        bins_in_use <= cfg_data[BINS_W-1:0];
      end
      if (cfg_index == CFG_BIN_WIDTH) begin
        bin_width <= cfg_data;
      end
    end
  end

  // Bins in use, limited to the built depth.
  always_comb begin
    if (32'(bins_in_use) > 32'(MAX_BINS)) begin
      nb = BINS_W'(MAX_BINS);
    end else begin
      nb = bins_in_use;
    end
  end

  bhist_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  bhist_datapath #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .status    (status),
    .nb        (nb),
    .bin_width (bin_width),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire
